FILE: rtl/core/dtfs_pkg.sv
// ----------------------------------------------------------------------------
// dtfs_pkg - shared types and constants
// Payload structs, event and status codes, and sizes for the drop-tail FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package dtfs_pkg;

  // Queue geometry
  localparam int DEPTH   = 128;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LEVEL_W = $clog2(DEPTH + 1);
  localparam int VALUE_W = 8;
  localparam int CAP_W   = 8;
  localparam int CMP_W   = (LEVEL_W > CAP_W) ? LEVEL_W : CAP_W;

  // Configuration
  localparam int            APB_AW       = 3;
  localparam int            APB_DW       = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;
  localparam logic          REG_CAPACITY = 1'b0;

  // Event kinds
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // Result status
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DROP  = 2'd1;
  localparam logic [1:0] STATUS_UNDER = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [VALUE_W-1:0] packet_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_value;
    logic        out_valid;
    logic [1:0]  status;
    logic [7:0]  occupancy;
    logic [31:0] lost_total;
    logic [7:0]  high_mark;
    logic [31:0] occupancy_sum;
    logic [15:0] ticks_seen;
  } out_item_t;

  // Broadcast to every slot cell
  typedef struct packed {
    logic               shift;
    logic               load;
    logic [IDX_W-1:0]   wr_idx;
    logic [VALUE_W-1:0] pkt;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/dtfs_cell.sv
// ----------------------------------------------------------------------------
// dtfs_cell - one packet slot
// Loads on enqueue when addressed, takes its upper neighbour's value on dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfs_cell (
  input  wire logic                        clk,
  input  wire dtfs_pkg::cell_ctl_t         ctl,
  input  wire logic [dtfs_pkg::IDX_W-1:0]  my_idx,
  input  wire logic [dtfs_pkg::VALUE_W-1:0] next_q,
  output logic      [dtfs_pkg::VALUE_W-1:0] q
);

  logic [dtfs_pkg::VALUE_W-1:0] q_r;
  logic [dtfs_pkg::VALUE_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.shift) begin
      q_nxt = next_q;
    end else if (ctl.load && (ctl.wr_idx == my_idx)) begin
      q_nxt = ctl.pkt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

FILE: rtl/core/dtfs_ctrl.sv
// ----------------------------------------------------------------------------
// dtfs_ctrl - fill level and statistics
// Decodes each event, steers the slot chain and keeps the saturating counters.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfs_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire dtfs_pkg::in_item_t            item,
  input  wire logic [dtfs_pkg::CAP_W-1:0]    capacity,
  input  wire logic [dtfs_pkg::VALUE_W-1:0]  head_q,
  output dtfs_pkg::cell_ctl_t                ctl,
  output dtfs_pkg::out_item_t                result
);

  logic [dtfs_pkg::LEVEL_W-1:0] fill_r,  fill_nxt;
  logic [31:0]                  drop_r,  drop_nxt;
  logic [dtfs_pkg::LEVEL_W-1:0] peak_r,  peak_nxt;
  logic [31:0]                  total_r, total_nxt;
  logic [15:0]                  ticks_r, ticks_nxt;

  logic [dtfs_pkg::CMP_W-1:0] cap_eff;
  logic                       full;
  logic                       empty;
  logic [32:0]                sum_wide;
  logic                       deq_ok;
  logic [1:0]                 status;

  // effective capacity saturates at the queue depth
  always_comb begin
    if (dtfs_pkg::CMP_W'(capacity) > dtfs_pkg::CMP_W'(dtfs_pkg::DEPTH)) begin
      cap_eff = dtfs_pkg::CMP_W'(dtfs_pkg::DEPTH);
    end else begin
      cap_eff = dtfs_pkg::CMP_W'(capacity);
    end
  end

  assign full     = dtfs_pkg::CMP_W'(fill_r) >= cap_eff;
  assign empty    = (fill_r == '0);
  assign sum_wide = {1'b0, total_r} + 33'(fill_r);

  always_comb begin
    fill_nxt   = fill_r;
    drop_nxt   = drop_r;
    peak_nxt   = peak_r;
    total_nxt  = total_r;
    ticks_nxt  = ticks_r;
    ctl.shift  = 1'b0;
    ctl.load   = 1'b0;
    ctl.wr_idx = fill_r[dtfs_pkg::IDX_W-1:0];
    ctl.pkt    = item.packet_value;
    deq_ok     = 1'b0;
    status     = dtfs_pkg::STATUS_OK;
    unique case (item.mode)
      dtfs_pkg::MODE_ENQ: begin
        if (full) begin
          status = dtfs_pkg::STATUS_DROP;
          if (drop_r != '1) begin
            drop_nxt = drop_r + 32'd1;
          end
        end else begin
          ctl.load = fire;
          fill_nxt = fill_r + dtfs_pkg::LEVEL_W'(1);
        end
      end
      dtfs_pkg::MODE_DEQ: begin
        if (empty) begin
          status = dtfs_pkg::STATUS_UNDER;
        end else begin
          deq_ok    = 1'b1;
          ctl.shift = fire;
          fill_nxt  = fill_r - dtfs_pkg::LEVEL_W'(1);
        end
      end
      dtfs_pkg::MODE_TICK: begin
        total_nxt = sum_wide[32] ? '1 : sum_wide[31:0];
        if (fill_r > peak_r) begin
          peak_nxt = fill_r;
        end
        if (ticks_r != '1) begin
          ticks_nxt = ticks_r + 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      drop_r  <= '0;
      peak_r  <= '0;
      total_r <= '0;
      ticks_r <= '0;
    end else if (fire) begin
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
      peak_r  <= peak_nxt;
      total_r <= total_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // result shows the state after the event
  always_comb begin
    result.out_value     = deq_ok ? 8'(head_q) : 8'd0;
    result.out_valid     = deq_ok;
    result.status        = status;
    result.occupancy     = 8'(fill_nxt);
    result.lost_total    = drop_nxt;
    result.high_mark     = 8'(peak_nxt);
    result.occupancy_sum = total_nxt;
    result.ticks_seen    = ticks_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/drop_tail_fifo_with_stats_top.sv
// ----------------------------------------------------------------------------
// drop_tail_fifo_with_stats_top - drop-tail packet FIFO with occupancy stats
// Each input transfer is one event: enqueue, dequeue, end of tick or a no-op
// (code 3). Every event yields exactly one result transfer carrying the state after it.
//
// Channels: in_valid/in_stall/in_data in, out_valid/out_stall/out_data out.
//   A transfer happens on a rising edge with valid high and stall low.
// Config: APB-style port, capacity at byte address 0 (reset 100, held at
//   the queue depth when larger). Write only while the block is idle.
// Output: the result is captured in the output register on the edge that
//   takes the input transfer.
// Throughput: one event per cycle while in_stall is low. The packet store is a
//   row of slot cells that shift towards the head on a dequeue, so every event
//   finishes in the cycle it is taken; the output register is the only buffering.
// Stall: while a result waits and out_stall is high, in_stall is raised;
//   an idle or draining output register keeps the input open.
// Reset: counters, fill level and output valid clear, capacity returns
//   to 100. Slot contents are not cleared; a slot is read only after it has
//   been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module drop_tail_fifo_with_stats_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input events
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire dtfs_pkg::in_item_t            in_data,
  // results
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output dtfs_pkg::out_item_t                out_data,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dtfs_pkg::APB_AW-1:0]   paddr,
  input  wire logic [dtfs_pkg::APB_DW-1:0]   pwdata,
  output logic      [dtfs_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  // --- configuration register ---
  logic [dtfs_pkg::CAP_W-1:0] cap_r;
  logic                       cfg_wr;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == dtfs_pkg::REG_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? dtfs_pkg::APB_DW'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= dtfs_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[dtfs_pkg::CAP_W-1:0];
    end
  end

  // --- input handshake ---
  logic out_valid_r;
  logic in_fire;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // --- control and statistics ---
  dtfs_pkg::cell_ctl_t  ctl;
  dtfs_pkg::cell_ctl_t  ctl_gated;
  dtfs_pkg::out_item_t  result;
  logic [dtfs_pkg::VALUE_W-1:0] cell_q [dtfs_pkg::DEPTH];

  dtfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .item     (in_data),
    .capacity (cap_r),
    .head_q   (cell_q[0]),
    .ctl      (ctl),
    .result   (result)
  );

  // shift and load only move the chain on a real transfer
  always_comb begin
    ctl_gated       = ctl;
    ctl_gated.shift = ctl.shift && in_fire;
    ctl_gated.load  = ctl.load && in_fire;
  end

  // --- slot chain: cell 0 holds the oldest packet ---
  for (genvar i = 0; i < dtfs_pkg::DEPTH; i++) begin : g_cell
    logic [dtfs_pkg::VALUE_W-1:0] upper_q;
    if (i == dtfs_pkg::DEPTH - 1) begin : g_last
      assign upper_q = '0;
    end else begin : g_mid
      assign upper_q = cell_q[i+1];
    end
    dtfs_cell u_cell (
      .clk    (clk),
      .ctl    (ctl_gated),
      .my_idx (dtfs_pkg::IDX_W'(i)),
      .next_q (upper_q),
      .q      (cell_q[i])
    );
  end

  // --- output register ---
  dtfs_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the drop-tail FIFO with occupancy statistics
// A table of directed events is walked first, then segmented random traffic
// under several capacities, a back-pressure burst and a run of tick events
// with a full queue. Every result transfer is compared field by field
// against a shadow model of the queue and its counters.
// ----------------------------------------------------------------------------

module tb;

  // Spare event code: no state change, plain status report
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Directed table row kinds
  localparam logic ROW_EVENT = 1'b0;
  localparam logic ROW_CFG   = 1'b1;

  localparam logic [dtfs_pkg::APB_AW-1:0] CAP_ADDR =
    dtfs_pkg::APB_AW'(4 * dtfs_pkg::REG_CAPACITY);

  localparam int IDLE_MAX      = 18;
  localparam int HOLD_OFF_LEN  = 300;   // long receiver hold-off, in cycles
  localparam int TICK_BURST    = 60;
  localparam int PHASE_ITEMS   = 185;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef struct packed {
    logic                is_cfg;
    logic [31:0]         cfg_value;
    dtfs_pkg::in_item_t  ev;
    logic                fixed;
    dtfs_pkg::out_item_t want;
  } stim_row_t;

  localparam dtfs_pkg::out_item_t PREDICTED = '0;
  localparam int NUM_ROWS = 26;

  // Directed part. Typed-in results only where they are obvious from the
  // zero state after reset; the rest come from the shadow model.
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // underflow and ticks on an empty queue
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_DEQ, 8'h00}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_UNDER, 8'd0, 32'd0, 8'd0, 32'd0, 16'd0}},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_TICK, 8'h00}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_OK, 8'd0, 32'd0, 8'd0, 32'd0, 16'd1}},
    '{ROW_EVENT, 32'd0, '{MODE_SPARE, 8'hFF}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_OK, 8'd0, 32'd0, 8'd0, 32'd0, 16'd1}},
    // payload extremes in and out
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'hFF}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_OK, 8'd1, 32'd0, 8'd0, 32'd0, 16'd1}},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'h00}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_OK, 8'd2, 32'd0, 8'd0, 32'd0, 16'd1}},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_TICK, 8'h5A}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_OK, 8'd2, 32'd0, 8'd2, 32'd2, 16'd2}},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_DEQ, 8'h00}, 1'b1,
      '{8'hFF, 1'b1, dtfs_pkg::STATUS_OK, 8'd1, 32'd0, 8'd2, 32'd2, 16'd2}},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_DEQ, 8'hFF}, 1'b1,
      '{8'h00, 1'b1, dtfs_pkg::STATUS_OK, 8'd0, 32'd0, 8'd2, 32'd2, 16'd2}},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_DEQ, 8'h00}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_UNDER, 8'd0, 32'd0, 8'd2, 32'd2, 16'd2}},
    // capacity one: second arrival drops
    '{ROW_CFG, 32'd1, '{dtfs_pkg::MODE_ENQ, 8'h00}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'h3C}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'hC3}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_DROP, 8'd1, 32'd1, 8'd2, 32'd2, 16'd2}},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_TICK, 8'h00}, 1'b0, PREDICTED},
    // capacity zero, lowered below the held level
    '{ROW_CFG, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'h00}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'h77}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_DEQ, 8'h00}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'h88}, 1'b1,
      '{8'h00, 1'b0, dtfs_pkg::STATUS_DROP, 8'd0, 32'd3, 8'd2, 32'd3, 16'd3}},
    // capacity two with spare code in between
    '{ROW_CFG, 32'd2, '{dtfs_pkg::MODE_ENQ, 8'h00}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'h01}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'h80}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_ENQ, 8'h7F}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{MODE_SPARE, 8'h00}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_TICK, 8'hFF}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_DEQ, 8'h00}, 1'b0, PREDICTED},
    '{ROW_EVENT, 32'd0, '{dtfs_pkg::MODE_DEQ, 8'h00}, 1'b0, PREDICTED},
    '{ROW_CFG, 32'd100, '{dtfs_pkg::MODE_ENQ, 8'h00}, 1'b0, PREDICTED}
  };

  // Capacities for the random phases: 128 with junk in the upper bits, just
  // above and far above the depth, the low end, the reset value and half the depth
  localparam logic [31:0] PHASE_CAPS [8] = '{
    32'hFFFF_FF80, 32'd255, 32'd129, 32'd1, 32'd0, 32'd2, 32'd100, 32'd64
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and block pins; everything starts at a known value
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid  = 1'b0;
  logic                in_stall;
  dtfs_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dtfs_pkg::out_item_t out_data;

  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [dtfs_pkg::APB_AW-1:0] paddr   = '0;
  logic [dtfs_pkg::APB_DW-1:0] pwdata  = '0;
  logic [dtfs_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  drop_tail_fifo_with_stats_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the queue and its counters, advanced once per input transfer
  // ---------------------------------------------------------------------------
  logic [dtfs_pkg::VALUE_W-1:0] pkt_shadow [$];
  logic [dtfs_pkg::CAP_W-1:0]   cap_shadow   = dtfs_pkg::CAP_RESET;
  logic [31:0]                  lost_shadow  = '0;
  logic [7:0]                   peak_shadow  = '0;
  logic [31:0]                  sum_shadow   = '0;
  logic [15:0]                  ticks_shadow = '0;

  // Results owed by the block, oldest first
  dtfs_pkg::out_item_t pending_reports [$];

  int  mismatch_count  = 0;
  bit  src_idle_on     = 1'b1;
  bit  snk_idle_on     = 1'b1;
  int  hold_off_cycles = 0;

  function automatic dtfs_pkg::out_item_t fifo_event_result(dtfs_pkg::in_item_t ev);
    dtfs_pkg::out_item_t res;
    int                  eff_cap;
    int                  level;
    logic [32:0]         wide_sum;
    res     = '0;
    // capacity above the depth is held at the depth
    eff_cap = (int'(cap_shadow) > dtfs_pkg::DEPTH) ? dtfs_pkg::DEPTH : int'(cap_shadow);
    level   = pkt_shadow.size();
    case (ev.mode)
      dtfs_pkg::MODE_ENQ: begin
        if (level >= eff_cap) begin
          res.status = dtfs_pkg::STATUS_DROP;
          if (lost_shadow != '1) lost_shadow++;
        end else begin
          pkt_shadow = {pkt_shadow, ev.packet_value};
        end
      end
      dtfs_pkg::MODE_DEQ: begin
        if (level == 0) begin
          res.status = dtfs_pkg::STATUS_UNDER;
        end else begin
          res.out_value = pkt_shadow.pop_front();
          res.out_valid = 1'b1;
        end
      end
      dtfs_pkg::MODE_TICK: begin
        wide_sum   = {1'b0, sum_shadow} + 33'(level);
        sum_shadow = wide_sum[32] ? '1 : wide_sum[31:0];
        if (level > int'(peak_shadow)) peak_shadow = 8'(level);
        if (ticks_shadow != '1) ticks_shadow++;
      end
      default: ;  // spare code leaves the state alone
    endcase
    res.occupancy     = 8'(pkt_shadow.size());
    res.lost_total    = lost_shadow;
    res.high_mark     = peak_shadow;
    res.occupancy_sum = sum_shadow;
    res.ticks_seen    = ticks_shadow;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side. valid stays high across back-to-back transfers; it is only
  // lowered when a gap is drawn or the caller pauses.
  // ---------------------------------------------------------------------------
  task automatic send_event(dtfs_pkg::in_item_t ev, logic use_fixed,
                            dtfs_pkg::out_item_t fixed_res);
    int                  gap;
    dtfs_pkg::out_item_t res;
    gap = src_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    res = fifo_event_result(ev);
    pending_reports = {pending_reports, (use_fixed ? fixed_res : res)};
  endtask

  // Drop valid and wait for every owed result, plus the output latency
  task automatic settle_queue();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Setup then access cycle, then read the register back
  task automatic write_capacity(logic [31:0] value);
    settle_queue();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_shadow = value[dtfs_pkg::CAP_W-1:0];
    @(posedge clk);
    check_field("capacity", 32'(cap_shadow), prdata);
  endtask

  // Random traffic in runs: long enqueue runs to fill up and overflow, long
  // dequeue runs to drain and underflow, short mixed stretches and tick runs
  task automatic run_traffic(int n_items);
    int                 sent;
    int                 seg;
    int                 run_len;
    int                 roll;
    dtfs_pkg::in_item_t ev;
    sent = 0;
    while (sent < n_items) begin
      seg     = $urandom_range(0, 9);
      run_len = (seg < 6) ? $urandom_range(1, 140) :
                (seg < 9) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      if (run_len > n_items - sent) run_len = n_items - sent;
      repeat (run_len) begin
        roll = $urandom_range(0, 15);
        if (seg < 3)
          ev.mode = (roll == 0) ? dtfs_pkg::MODE_TICK :
                    (roll == 1) ? dtfs_pkg::MODE_DEQ : dtfs_pkg::MODE_ENQ;
        else if (seg < 6)
          ev.mode = (roll == 0) ? dtfs_pkg::MODE_TICK :
                    (roll == 1) ? dtfs_pkg::MODE_ENQ : dtfs_pkg::MODE_DEQ;
        else if (seg < 9)
          ev.mode = (roll < 6)  ? dtfs_pkg::MODE_ENQ :
                    (roll < 11) ? dtfs_pkg::MODE_DEQ :
                    (roll < 15) ? dtfs_pkg::MODE_TICK : MODE_SPARE;
        else
          ev.mode = (roll < 14) ? dtfs_pkg::MODE_TICK : MODE_SPARE;
        ev.packet_value = 8'($urandom_range(0, 255));
        send_event(ev, 1'b0, PREDICTED);
      end
      sent += run_len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall for a drawn number of cycles, then take one transfer
  // and compare it with the oldest owed result
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int                  stall_len;
    dtfs_pkg::out_item_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall_len       = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall_len = snk_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result expected none actual %0h", $time, out_data);
      end else begin
        want = pending_reports.pop_front();
        check_field("out_value", 32'(want.out_value), 32'(out_data.out_value));
        check_field("out_valid", 32'(want.out_valid), 32'(out_data.out_valid));
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
        check_field("lost_total", want.lost_total, out_data.lost_total);
        check_field("high_mark", 32'(want.high_mark), 32'(out_data.high_mark));
        check_field("occupancy_sum", want.occupancy_sum, out_data.occupancy_sum);
        check_field("ticks_seen", 32'(want.ticks_seen), 32'(out_data.ticks_seen));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dtfs_pkg::in_item_t ev;
    int                 drain_cycles;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, idling on both sides
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].is_cfg == ROW_CFG)
        write_capacity(DIRECTED[r].cfg_value);
      else
        send_event(DIRECTED[r].ev, DIRECTED[r].fixed, DIRECTED[r].want);
    end

    // Back-pressure: the receiver takes one transfer and then holds off for
    // a long stretch while the sender offers items without gaps, so the
    // output register fills and the input is stalled. The sender then
    // pauses until every owed result has come.
    settle_queue();
    src_idle_on     = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    run_traffic(30);
    settle_queue();

    // random phases across the capacity settings; some without idling
    for (int p = 0; p <= 8; p++) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      write_capacity((p < 8) ? PHASE_CAPS[p] : 32'($urandom()));
      run_traffic(PHASE_ITEMS);
    end

    // Fill past the depth, then run ticks flat out with a full queue
    // behind the sum and the peak
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    write_capacity(32'd128);
    repeat (dtfs_pkg::DEPTH + 12) begin
      ev.mode         = dtfs_pkg::MODE_ENQ;
      ev.packet_value = 8'($urandom_range(0, 255));
      send_event(ev, 1'b0, PREDICTED);
    end
    repeat (TICK_BURST) begin
      ev.mode         = dtfs_pkg::MODE_TICK;
      ev.packet_value = 8'($urandom_range(0, 255));
      send_event(ev, 1'b0, PREDICTED);
    end
    snk_idle_on = 1'b1;
    src_idle_on = 1'b1;
    run_traffic(40);

    // wind down: wait for the last results, then a few quiet cycles
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (pending_reports.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (pending_reports.size() != 0) begin
      mismatch_count++;
      $display("%0t ns: results expected %0d more actual 0", $time,
               pending_reports.size());
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
